/* sv/assert_macros.svh */
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk_s, rst_n, expr, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* sv/dpps_pkg.sv */
// Types, codes and constants shared by the scheduler modules.
package dpps_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int RUN_PENALTY = 3;
	localparam int DONE_MAX = 31;

	// Register index of process_count on the configuration port.
	localparam logic PCOUNT_IDX = 1'b0;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] ST_FINAL   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_READY   = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	localparam logic signed [15:0] PRI_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PRI_MIN = 16'sh8000;

	// One table entry as it is kept in the entry memory.
	typedef struct packed {
		logic signed [15:0] pri;
		logic [15:0]        used;
		logic [15:0]        remaining;
		logic [15:0]        block_after;
		logic [15:0]        block_duration;
		logic [15:0]        run_cd;
		logic [15:0]        block_cd;
	} entry_t;

	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_en;
		logic disp_rd;
		logic disp_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic disp_req;
	} dp_status_t;

endpackage

/* sv/dynamic_priority_process_scheduler_core.sv */
// A load word goes from its accept cycle straight to the result cycle. A tick word walks the
// n active entries (process_count clamped to MAX_PROCS) through the entry memory, one entry
// per cycle; each read is registered before the entry is updated and written back. When an
// entry is dispatched, the walk is followed by a read and a write back of the chosen entry;
// with no active entry the walk ends without reading any entry. busy is high from the cycle
// after acceptance until the result cycle, and the result word is shown for exactly one cycle
// with done high; the receiver cannot stall it, so capture it in that cycle. process_count
// must be written through the APB port only while busy is low; the block does not enforce it.
module dynamic_priority_process_scheduler_core #(
	parameter int MAX_PROCS = dpps_pkg::MAX_PROCS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [3:0]         slot,
	input  logic signed [15:0] priority_in,
	input  logic [15:0]        used_time_in,
	input  logic [15:0]        remaining_in,
	input  logic [15:0]        block_after_in,
	input  logic [15:0]        block_duration_in,
	input  logic [1:0]         state_in,
	output logic               done,
	output logic [3:0]         running_id,
	output logic               running_valid,
	output logic [15:0]        ready_mask,
	output logic [15:0]        blocked_mask,
	output logic [4:0]         finished_count,
	output logic               all_done
);

	dpps_pkg::ctrl_cmd_t  cmd;
	dpps_pkg::dp_status_t status;
	logic [4:0]           pcount_q;
	logic                 pcount_sel;

	assign pready = 1'b1;
	assign pcount_sel = (paddr[2] == dpps_pkg::PCOUNT_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= 5'd1;
		end else if (psel && penable && pwrite && pcount_sel) begin
			pcount_q <= pwdata[4:0];
		end
	end

	assign prdata = pcount_sel ? {27'd0, pcount_q} : 32'd0;

	dpps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dpps_datapath #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.process_count     (pcount_q),
		.slot              (slot),
		.priority_in       (priority_in),
		.used_time_in      (used_time_in),
		.remaining_in      (remaining_in),
		.block_after_in    (block_after_in),
		.block_duration_in (block_duration_in),
		.state_in          (state_in),
		.running_id        (running_id),
		.running_valid     (running_valid),
		.ready_mask        (ready_mask),
		.blocked_mask      (blocked_mask),
		.finished_count    (finished_count),
		.all_done          (all_done)
	);

endmodule

/* sv/dpps_ctrl.sv */
// Controller state machine that sequences loads, table walks and dispatch.
module dpps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  kind,
	input  dpps_pkg::dp_status_t  status,
	output dpps_pkg::ctrl_cmd_t   cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_DRD  = 5'b00100,
		S_DWR  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == dpps_pkg::KIND_TICK) begin
						cmd.walk_start = 1'b1;
						state_d = S_WALK;
					end else begin
						cmd.load = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (status.walk_done) begin
					state_d = status.disp_req ? S_DRD : S_DONE;
				end
			end
			S_DRD: begin
				cmd.disp_rd = 1'b1;
				state_d = S_DWR;
			end
			S_DWR: begin
				cmd.disp_wr = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

/* sv/dpps_datapath.sv */
// Entry table, per-entry update logic, candidate search and result registers.
module dpps_datapath #(
	parameter int MAX_PROCS = dpps_pkg::MAX_PROCS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dpps_pkg::ctrl_cmd_t   cmd,
	output dpps_pkg::dp_status_t  status,
	input  logic [4:0]            process_count,
	input  logic [3:0]            slot,
	input  logic signed [15:0]    priority_in,
	input  logic [15:0]           used_time_in,
	input  logic [15:0]           remaining_in,
	input  logic [15:0]           block_after_in,
	input  logic [15:0]           block_duration_in,
	input  logic [1:0]            state_in,
	output logic [3:0]            running_id,
	output logic                  running_valid,
	output logic [15:0]           ready_mask,
	output logic [15:0]           blocked_mask,
	output logic [4:0]            finished_count,
	output logic                  all_done
);

	localparam int IW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);

	dpps_pkg::entry_t mem_q [MAX_PROCS];
	dpps_pkg::entry_t rdata_s1;
	dpps_pkg::entry_t wdata;
	dpps_pkg::entry_t upd;
	logic [IW-1:0]    raddr, waddr;
	logic             we;

	// Entry state as three bit vectors; no bit set means final.
	logic [MAX_PROCS-1:0] run_q, rdy_q, blk_q;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_act;
	logic               pend_s1;
	logic [IW-1:0]      idx_s1;
	logic               have_q;
	logic signed [15:0] best_pri_q;
	logic [IW-1:0]      best_idx_q;
	logic               busy_q;
	logic [4:0]         done_q;
	logic               run_valid_q;
	logic [3:0]         run_id_q;

	logic               issue;
	logic               load_ok;
	logic [IW-1:0]      slot_idx;
	logic               st_run, st_rdy, st_blk;
	logic               n_run, n_rdy, n_blk;
	logic               cand, fin, blk_now;
	logic signed [16:0] pri_m3;
	logic [15:0]        rem_new, rcd_new, bcd_new;

	assign n_act = (32'(process_count) > MAX_PROCS) ? CW'(MAX_PROCS) : CW'(process_count);
	assign issue = cmd.walk_en && (cnt_q < n_act);
	assign slot_idx = IW'(slot);
	assign load_ok = cmd.load && (32'(slot) < MAX_PROCS);
	assign raddr = cmd.disp_rd ? best_idx_q : cnt_q[IW-1:0];

	// Update of the entry that was read in the previous walk cycle.
	assign st_run = run_q[idx_s1];
	assign st_rdy = rdy_q[idx_s1];
	assign st_blk = blk_q[idx_s1];
	assign pri_m3 = {rdata_s1.pri[15], rdata_s1.pri} - 17'(dpps_pkg::RUN_PENALTY);
	assign rem_new = (rdata_s1.remaining != 16'd0) ? rdata_s1.remaining - 16'd1 : 16'd0;
	assign rcd_new = (rdata_s1.run_cd != 16'd0) ? rdata_s1.run_cd - 16'd1 : 16'd0;
	assign bcd_new = (rdata_s1.block_cd != 16'd0) ? rdata_s1.block_cd - 16'd1 : 16'd0;

	always_comb begin
		upd = rdata_s1;
		n_run = st_run;
		n_rdy = st_rdy;
		n_blk = st_blk;
		cand = 1'b0;
		fin = 1'b0;
		blk_now = 1'b0;
		if (st_rdy) begin
			cand = 1'b1;
			if (rdata_s1.pri != dpps_pkg::PRI_MAX) begin
				upd.pri = rdata_s1.pri + 16'sd1;
			end
		end else if (st_run) begin
			// The 17-bit difference leaves the 16-bit range when its top two bits differ.
			upd.pri = (pri_m3[16] != pri_m3[15]) ? dpps_pkg::PRI_MIN : pri_m3[15:0];
			upd.used = (rdata_s1.used != 16'hFFFF) ? rdata_s1.used + 16'd1 : rdata_s1.used;
			upd.remaining = rem_new;
			upd.run_cd = rcd_new;
			if (rem_new == 16'd0) begin
				fin = 1'b1;
				n_run = 1'b0;
			end else if (rcd_new == 16'd0 && rdata_s1.block_after != 16'd0) begin
				blk_now = 1'b1;
				n_run = 1'b0;
				n_blk = 1'b1;
				upd.block_cd = rdata_s1.block_duration;
			end
		end else if (st_blk) begin
			upd.block_cd = bcd_new;
			if (bcd_new == 16'd0) begin
				n_blk = 1'b0;
				n_rdy = 1'b1;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_s1;
		wdata = upd;
		if (load_ok) begin
			we = 1'b1;
			waddr = slot_idx;
			wdata.pri = priority_in;
			wdata.used = used_time_in;
			wdata.remaining = remaining_in;
			wdata.block_after = block_after_in;
			wdata.block_duration = block_duration_in;
			wdata.run_cd = 16'd0;
			wdata.block_cd = 16'd0;
		end else if (pend_s1) begin
			we = 1'b1;
		end else if (cmd.disp_wr) begin
			we = 1'b1;
			waddr = best_idx_q;
			wdata = rdata_s1;
			wdata.run_cd = rdata_s1.block_after;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			rdy_q <= '0;
			blk_q <= '0;
		end else if (load_ok) begin
			run_q[slot_idx] <= (state_in == dpps_pkg::ST_RUNNING);
			rdy_q[slot_idx] <= (state_in == dpps_pkg::ST_READY);
			blk_q[slot_idx] <= (state_in == dpps_pkg::ST_BLOCKED);
		end else if (pend_s1) begin
			run_q[idx_s1] <= n_run;
			rdy_q[idx_s1] <= n_rdy;
			blk_q[idx_s1] <= n_blk;
		end else if (cmd.disp_wr) begin
			run_q[best_idx_q] <= 1'b1;
			rdy_q[best_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			idx_s1 <= '0;
			have_q <= 1'b0;
			best_pri_q <= '0;
			best_idx_q <= '0;
			busy_q <= 1'b0;
			done_q <= '0;
			run_valid_q <= 1'b0;
			run_id_q <= '0;
		end else begin
			if (cmd.load || cmd.walk_start) begin
				run_valid_q <= 1'b0;
				run_id_q <= '0;
			end
			if (cmd.walk_start) begin
				cnt_q <= '0;
				pend_s1 <= 1'b0;
				have_q <= 1'b0;
			end else if (cmd.walk_en) begin
				pend_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
					idx_s1 <= cnt_q[IW-1:0];
				end
			end
			if (pend_s1) begin
				// Entries come in rising index order, so >= hands ties to the higher index.
				if (cand && (!have_q || upd.pri >= best_pri_q)) begin
					have_q <= 1'b1;
					best_pri_q <= upd.pri;
					best_idx_q <= idx_s1;
				end
				if (fin || blk_now) begin
					busy_q <= 1'b0;
				end
				if (fin && (done_q != 5'(dpps_pkg::DONE_MAX))) begin
					done_q <= done_q + 5'd1;
				end
			end
			if (cmd.disp_wr) begin
				busy_q <= 1'b1;
				run_valid_q <= 1'b1;
				run_id_q <= 4'(best_idx_q);
			end
		end
	end

	assign status.walk_done = !pend_s1 && (cnt_q >= n_act);
	assign status.disp_req = have_q && !busy_q;

	for (genvar b = 0; b < 16; b++) begin : g_mask
		if (b < MAX_PROCS) begin : g_live
			assign ready_mask[b] = rdy_q[b] && (32'(n_act) > b);
			assign blocked_mask[b] = blk_q[b] && (32'(n_act) > b);
		end else begin : g_none
			assign ready_mask[b] = 1'b0;
			assign blocked_mask[b] = 1'b0;
		end
	end

	assign running_id = run_id_q;
	assign running_valid = run_valid_q;
	assign finished_count = done_q;
	assign all_done = (32'(done_q) == 32'(n_act));

endmodule

/* sv/dpps_checker.sv */
// Port-level checker for the scheduler core and its bind to the top level.
`include "assert_macros.svh"

module dpps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       running_valid,
	input logic [3:0] running_id
);

	// An accepted word keeps the core busy until its result has gone out.
	`ASSERT_PROP(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy low after accept")
	// A result word is shown only while the core is still busy with it.
	`ASSERT_NEVER(a_done_idle, clk, arst_n, done && !busy, "result shown while idle")
	// Each result word lasts a single cycle.
	`ASSERT_PROP(a_done_once, clk, arst_n, done |=> !done, "result repeated")
	// Without a dispatch the reported entry reads as zero.
	`ASSERT_NEVER(a_id_zero, clk, arst_n, done && !running_valid && (running_id != 4'd0),
		"running_id set without dispatch")

endmodule

bind dynamic_priority_process_scheduler_core dpps_checker u_dpps_checker (.*);

/* tb/tb_dynamic_priority_process_scheduler_core.sv */
// Self-checking testbench for the dynamic priority process scheduler core.
module tb_dynamic_priority_process_scheduler_core;

	localparam int TABLE_SIZE = dpps_pkg::MAX_PROCS_DEF;

	typedef struct packed {
		logic               kind;
		logic [3:0]         slot;
		logic signed [15:0] pri;
		logic [15:0]        used;
		logic [15:0]        remaining;
		logic [15:0]        block_after;
		logic [15:0]        block_duration;
		logic [1:0]         state;
	} sched_word_t;

	typedef struct packed {
		logic [3:0]  running_id;
		logic        running_valid;
		logic [15:0] ready_mask;
		logic [15:0] blocked_mask;
		logic [4:0]  finished_count;
		logic        all_done;
	} sched_status_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic               kind;
	logic [3:0]         slot;
	logic signed [15:0] priority_in;
	logic [15:0]        used_time_in;
	logic [15:0]        remaining_in;
	logic [15:0]        block_after_in;
	logic [15:0]        block_duration_in;
	logic [1:0]         state_in;
	logic               done;
	logic [3:0]         running_id;
	logic               running_valid;
	logic [15:0]        ready_mask;
	logic [15:0]        blocked_mask;
	logic [4:0]         finished_count;
	logic               all_done;

	// Predicted scheduler state.
	logic signed [15:0] proc_pri [TABLE_SIZE];
	logic [15:0]        proc_used [TABLE_SIZE];
	logic [15:0]        proc_remaining [TABLE_SIZE];
	logic [15:0]        proc_block_after [TABLE_SIZE];
	logic [15:0]        proc_block_duration [TABLE_SIZE];
	logic [16:0]        proc_run_cd [TABLE_SIZE];
	logic [16:0]        proc_block_cd [TABLE_SIZE];
	logic [1:0]         proc_state [TABLE_SIZE];
	logic               cpu_taken;
	logic [4:0]         finish_total;
	logic [4:0]         proc_setting;

	sched_status_t pending_status[$];
	int unsigned   mismatches;

	dynamic_priority_process_scheduler_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.start             (start),
		.busy              (busy),
		.kind              (kind),
		.slot              (slot),
		.priority_in       (priority_in),
		.used_time_in      (used_time_in),
		.remaining_in      (remaining_in),
		.block_after_in    (block_after_in),
		.block_duration_in (block_duration_in),
		.state_in          (state_in),
		.done              (done),
		.running_id        (running_id),
		.running_valid     (running_valid),
		.ready_mask        (ready_mask),
		.blocked_mask      (blocked_mask),
		.finished_count    (finished_count),
		.all_done          (all_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// Applies one word to the predicted state and returns the status it produces.
	function automatic sched_status_t advance_schedule(input sched_word_t w);
		sched_status_t r;
		int            n;
		int            i;
		int            best;
		int            p;
		bit            have;
		bit            cand [TABLE_SIZE];
		r = '0;
		n = (proc_setting > TABLE_SIZE) ? TABLE_SIZE : proc_setting;
		if (w.kind == dpps_pkg::KIND_LOAD) begin
			proc_pri[w.slot] = w.pri;
			proc_used[w.slot] = w.used;
			proc_remaining[w.slot] = w.remaining;
			proc_block_after[w.slot] = w.block_after;
			proc_block_duration[w.slot] = w.block_duration;
			proc_state[w.slot] = w.state;
			proc_run_cd[w.slot] = '0;
			proc_block_cd[w.slot] = '0;
		end else begin
			for (i = 0; i < n; i++)
				cand[i] = (proc_state[i] == dpps_pkg::ST_READY);
			for (i = 0; i < n; i++) begin
				case (proc_state[i])
					dpps_pkg::ST_READY: begin
						if (proc_pri[i] != dpps_pkg::PRI_MAX)
							proc_pri[i] = proc_pri[i] + 16'sd1;
					end
					dpps_pkg::ST_RUNNING: begin
						p = int'(proc_pri[i]) - dpps_pkg::RUN_PENALTY;
						proc_pri[i] = (p < -32768) ? dpps_pkg::PRI_MIN : 16'(p);
						if (proc_used[i] != 16'hFFFF)
							proc_used[i] = proc_used[i] + 16'd1;
						if (proc_remaining[i] != 0)
							proc_remaining[i] = proc_remaining[i] - 16'd1;
						if (proc_run_cd[i] != 0)
							proc_run_cd[i] = proc_run_cd[i] - 17'd1;
						if (proc_remaining[i] == 0) begin
							proc_state[i] = dpps_pkg::ST_FINAL;
							cpu_taken = 1'b0;
							if (finish_total != dpps_pkg::DONE_MAX)
								finish_total = finish_total + 5'd1;
						end else if (proc_run_cd[i] == 0 && proc_block_after[i] != 0) begin
							proc_state[i] = dpps_pkg::ST_BLOCKED;
							proc_block_cd[i] = {1'b0, proc_block_duration[i]};
							cpu_taken = 1'b0;
						end
					end
					dpps_pkg::ST_BLOCKED: begin
						if (proc_block_cd[i] != 0)
							proc_block_cd[i] = proc_block_cd[i] - 17'd1;
						if (proc_block_cd[i] == 0)
							proc_state[i] = dpps_pkg::ST_READY;
					end
					default: ;
				endcase
			end
			have = 1'b0;
			best = 0;
			// Ties go to the later entry, hence the greater-or-equal compare.
			for (i = 0; i < n; i++) begin
				if (cand[i] && (!have || proc_pri[i] >= proc_pri[best])) begin
					best = i;
					have = 1'b1;
				end
			end
			if (!cpu_taken && have) begin
				proc_state[best] = dpps_pkg::ST_RUNNING;
				proc_run_cd[best] = {1'b0, proc_block_after[best]};
				cpu_taken = 1'b1;
				r.running_id = 4'(best);
				r.running_valid = 1'b1;
			end
		end
		for (i = 0; i < n; i++) begin
			if (proc_state[i] == dpps_pkg::ST_READY)
				r.ready_mask[i] = 1'b1;
			if (proc_state[i] == dpps_pkg::ST_BLOCKED)
				r.blocked_mask[i] = 1'b1;
		end
		r.finished_count = finish_total;
		r.all_done = (int'(finish_total) == n);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		sched_status_t want;
		if (arst_n && done) begin
			if (pending_status.size() == 0) begin
				$display("%0t: status word with none expected, expected none, actual id %0d",
					$time, running_id);
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				check_field("running_id", want.running_id, running_id);
				check_field("running_valid", want.running_valid, running_valid);
				check_field("ready_mask", want.ready_mask, ready_mask);
				check_field("blocked_mask", want.blocked_mask, blocked_mask);
				check_field("finished_count", want.finished_count, finished_count);
				check_field("all_done", want.all_done, all_done);
			end
		end
	end

	function automatic logic [15:0] spread16();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 6));
		endcase
	endfunction

	function automatic sched_word_t load_word(input logic [3:0] s, input logic signed [15:0] p,
			input logic [15:0] u, input logic [15:0] rem, input logic [15:0] after,
			input logic [15:0] dur, input logic [1:0] st);
		sched_word_t w;
		w.kind = dpps_pkg::KIND_LOAD;
		w.slot = s;
		w.pri = p;
		w.used = u;
		w.remaining = rem;
		w.block_after = after;
		w.block_duration = dur;
		w.state = st;
		return w;
	endfunction

	// A tick ignores the load fields, so they carry random junk.
	function automatic sched_word_t tick_word();
		sched_word_t w;
		w = load_word(4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 2'($urandom));
		w.kind = dpps_pkg::KIND_TICK;
		return w;
	endfunction

	task automatic send_word(input sched_word_t w);
		repeat ($urandom_range(0, 7)) @(negedge clk);
		@(negedge clk);
		kind <= w.kind;
		slot <= w.slot;
		priority_in <= w.pri;
		used_time_in <= w.used;
		remaining_in <= w.remaining;
		block_after_in <= w.block_after;
		block_duration_in <= w.block_duration;
		state_in <= w.state;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_status.push_back(advance_schedule(w));
		@(negedge clk);
		start <= 1'b0;
	endtask

	// One APB transfer to the process count register; a read is checked against the model.
	task automatic apb_transfer(input bit is_write, input logic [4:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= {dpps_pkg::PCOUNT_IDX, 2'b00};
		pwdata <= {27'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write)
			proc_setting = value;
		else if (prdata !== {27'd0, proc_setting}) begin
			$display("%0t: process_count readback mismatch, expected %0d, actual %0d",
				$time, proc_setting, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_process_count(input logic [4:0] value);
		while (pending_status.size() != 0 || busy)
			@(posedge clk);
		apb_transfer(1'b1, value);
		apb_transfer(1'b0, '0);
	endtask

	task automatic test_reset_defaults();
		apb_transfer(1'b0, '0);
		send_word(tick_word());
		send_word(load_word(4'd15, 16'sd5, 16'd0, 16'd3, 16'd0, 16'd0, dpps_pkg::ST_READY));
	endtask

	// Saturating priorities tie, a running entry finishes from zero remaining, and an entry
	// that unblocks in a tick is not dispatched in it.
	task automatic test_aging_and_ties();
		int k;
		set_process_count(5'd4);
		send_word(load_word(4'd0, dpps_pkg::PRI_MAX, 16'd0, 16'd4, 16'd0, 16'd0,
			dpps_pkg::ST_READY));
		send_word(load_word(4'd1, dpps_pkg::PRI_MAX, 16'd7, 16'd3, 16'd0, 16'd0,
			dpps_pkg::ST_READY));
		send_word(load_word(4'd2, dpps_pkg::PRI_MIN, 16'hFFFF, 16'd0, 16'd0, 16'd0,
			dpps_pkg::ST_RUNNING));
		send_word(load_word(4'd3, -16'sd2, 16'd0, 16'd2, 16'd0, 16'd0,
			dpps_pkg::ST_BLOCKED));
		for (k = 0; k < 3; k++)
			send_word(tick_word());
	endtask

	task automatic test_blocking();
		int k;
		set_process_count(5'd2);
		send_word(load_word(4'd0, 16'sd10, 16'd0, 16'd6, 16'd2, 16'd1, dpps_pkg::ST_READY));
		send_word(load_word(4'd1, dpps_pkg::PRI_MIN, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
			dpps_pkg::ST_READY));
		for (k = 0; k < 6; k++)
			send_word(tick_word());
	endtask

	task automatic test_several_running();
		set_process_count(5'd3);
		send_word(load_word(4'd0, 16'sd0, 16'd0, 16'd1, 16'd0, 16'd0, dpps_pkg::ST_RUNNING));
		send_word(load_word(4'd1, 16'sd1, 16'd0, 16'd2, 16'd1, 16'd0, dpps_pkg::ST_RUNNING));
		send_word(load_word(4'd2, -16'sd1, 16'd0, 16'd0, 16'd0, 16'd0, dpps_pkg::ST_RUNNING));
		send_word(tick_word());
		send_word(tick_word());
	endtask

	// No active entry at all, then a count above the table size.
	task automatic test_count_limits();
		set_process_count(5'd0);
		send_word(tick_word());
		send_word(load_word(4'd0, 16'sd3, 16'd0, 16'd1, 16'd0, 16'd0, dpps_pkg::ST_READY));
		set_process_count(5'd31);
		send_word(tick_word());
		send_word(tick_word());
	endtask

	task automatic run_random_phase(input logic [4:0] setting, input int count);
		int         n;
		int         k;
		logic [1:0] st;
		set_process_count(setting);
		n = (setting > TABLE_SIZE) ? TABLE_SIZE : setting;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: st = dpps_pkg::ST_READY;
				5, 6: st = dpps_pkg::ST_RUNNING;
				7, 8: st = dpps_pkg::ST_BLOCKED;
				default: st = dpps_pkg::ST_FINAL;
			endcase
			// Fill the active table first, then mostly tick with some reloads.
			if (k < n)
				send_word(load_word(4'(k), 16'($urandom), 16'($urandom), spread16(),
					spread16(), spread16(), st));
			else if ($urandom_range(0, 9) < 7)
				send_word(tick_word());
			else if (n > 0 && $urandom_range(0, 3) != 0)
				send_word(load_word(4'($urandom_range(0, n - 1)), spread16(), spread16(),
					spread16(), spread16(), spread16(), st));
			else
				send_word(load_word(4'($urandom), 16'($urandom), 16'($urandom), spread16(),
					spread16(), spread16(), 2'($urandom)));
		end
	endtask

	task automatic test_random();
		logic [4:0] settings [9];
		int         k;
		settings = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5, 5'd2, 5'd16, 5'd8};
		settings[6] = 5'($urandom_range(2, 15));
		for (k = 0; k < 9; k++)
			run_random_phase(settings[k], 50);
	endtask

	initial begin
		int k;
		mismatches = 0;
		cpu_taken = 1'b0;
		finish_total = '0;
		proc_setting = 5'd1;
		for (k = 0; k < TABLE_SIZE; k++) begin
			proc_pri[k] = '0;
			proc_used[k] = '0;
			proc_remaining[k] = '0;
			proc_block_after[k] = '0;
			proc_block_duration[k] = '0;
			proc_run_cd[k] = '0;
			proc_block_cd[k] = '0;
			proc_state[k] = dpps_pkg::ST_FINAL;
		end
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		kind = dpps_pkg::KIND_LOAD;
		slot = '0;
		priority_in = '0;
		used_time_in = '0;
		remaining_in = '0;
		block_after_in = '0;
		block_duration_in = '0;
		state_in = dpps_pkg::ST_FINAL;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_aging_and_ties();
		test_blocking();
		test_several_running();
		test_count_limits();
		test_random();

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
